// ===== hw/rtl/wsc_pkg.sv =====
// Shared types and fixed widths for the WSClock page replacement block.
package wsc_pkg;

   localparam int ADDR_W   = 64;
   localparam int TIME_W   = 32;
   localparam int PAGE_W   = 52;
   localparam int FRAME_W  = 10;
   localparam int OFFS_W   = 5;
   localparam int CSR_W    = 32;
   localparam int CSR_IX_W = 1;

   localparam logic [OFFS_W-1:0] OFFS_RESET  = 5'd14;
   localparam logic [TIME_W-1:0] THETA_RESET = 32'd1000;

   localparam logic [CSR_IX_W-1:0] CSR_PAGE_OFFSET = 1'b0;
   localparam logic [CSR_IX_W-1:0] CSR_THETA       = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [FRAME_W-1:0] frame;
      logic              evicted_valid;
      logic [PAGE_W-1:0] evicted_page;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              used;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic fill_inc;
   } store_ctl_type;

endpackage

// ===== hw/rtl/wsc_frame_store.sv =====
// Frame table memory with fill-count based residency.
module wsc_frame_store #(
   parameter int FRAMES = 1024,
   parameter int IW     = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wsc_pkg::store_ctl_type ctl,
   input  logic [IW-1:0]          rd_addr,
   input  logic [IW-1:0]          wr_addr,
   input  wsc_pkg::entry_type     wr_data,
   output wsc_pkg::entry_type     rd_data,
   output logic                   rd_valid
);
   localparam int CW = $clog2(FRAMES + 1);

   wsc_pkg::entry_type mem [FRAMES];
   wsc_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;
   logic               rd_valid_in;
   logic [CW-1:0]      fill_ff;
   logic [CW-1:0]      fill_in;
   logic [IW-1:0]      prev_slot;

   // Frames fill in hand order starting at one, so slot (addr-1) below fill is resident.
   always_comb begin
      prev_slot   = (rd_addr == '0) ? IW'(FRAMES - 1) : rd_addr - IW'(1);
      rd_valid_in = CW'(prev_slot) < fill_ff;
      fill_in     = ctl.fill_inc ? fill_ff + CW'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(FRAMES)) else $error("fill count beyond frame count");
   a_fill_full: assert property (@(posedge clock) disable iff (reset)
      ctl.fill_inc |-> fill_ff != CW'(FRAMES)) else $error("fill of a full table");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en)) else $error("read and write in one cycle");
`endif

endmodule

// ===== hw/rtl/wsclock_page_replacement.sv =====
// Top level of the WSClock page replacement block.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_data  (address, now)
//  rsp      out        rsp_valid / rsp_stall  rsp_data  (hit, frame, evicted_valid, evicted_page)
//  csr      in         csr_we                 csr_index, csr_wdata
//
// One transaction at a time. Each frame probe is a read then a compare
// (states HRD and HEV). A hit ends at the first matching frame; a miss
// scans all frames and then sweeps the hand (states SRD and SEV) over
// up to FRAMES frames.
// Reset is synchronous; it empties the table through the fill count, so no
// clearing pass is needed. A finished result waits in the output register
// while rsp_stall is high; the next request is taken in the meantime.
module wsclock_page_replacement #(
   parameter int FRAMES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  wsc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output wsc_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [wsc_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [wsc_pkg::CSR_W-1:0]  csr_wdata
);
   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_HRD  = 6'b000010,
      ST_HEV  = 6'b000100,
      ST_SRD  = 6'b001000,
      ST_SEV  = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [wsc_pkg::OFFS_W-1:0]    offs_ff, offs_in;
   logic [wsc_pkg::TIME_W-1:0]    theta_ff, theta_in;
   logic [wsc_pkg::PAGE_W-1:0]    page_ff, page_in;
   logic [wsc_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic [IW-1:0]                 hand_ff, hand_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   wsc_pkg::rsp_type              res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   wsc_pkg::rsp_type              rsp_ff, rsp_in;

   wsc_pkg::store_ctl_type        ctl;
   logic [IW-1:0]                 rd_addr;
   logic [IW-1:0]                 wr_addr;
   wsc_pkg::entry_type            wr_data;
   wsc_pkg::entry_type            rd_data;
   logic                          rd_valid;

   logic                          req_take;
   logic                          rsp_free;
   logic [IW-1:0]                 hand_nx;
   logic [wsc_pkg::TIME_W-1:0]    age;

   wsc_frame_store #(.FRAMES(FRAMES), .IW(IW)) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign hand_nx   = (hand_ff == IW'(FRAMES - 1)) ? '0 : hand_ff + IW'(1);
   assign age       = now_ff - rd_data.stamp;

   // Configuration registers: the user must write them only while idle; the block does not enforce it.
   always_comb begin
      offs_in  = offs_ff;
      theta_in = theta_ff;
      if (csr_we) begin
         case (csr_index)
            wsc_pkg::CSR_PAGE_OFFSET: offs_in  = csr_wdata[wsc_pkg::OFFS_W-1:0];
            wsc_pkg::CSR_THETA:       theta_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      page_in  = page_ff;
      now_in   = now_ff;
      idx_in   = idx_ff;
      hand_in  = hand_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      ctl      = '0;
      rd_addr  = idx_ff;
      wr_addr  = idx_ff;
      wr_data  = '{page: page_ff, used: 1'b0, stamp: now_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               page_in  = wsc_pkg::PAGE_W'(req_data.address >> offs_ff);
               now_in   = req_data.now;
               idx_in   = '0;
               state_in = ST_HRD;
            end
         end
         ST_HRD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_HEV;
         end
         ST_HEV: begin
            // Lowest matching resident frame wins; stamp it and set its use bit.
            if (rd_valid && rd_data.page == page_ff) begin
               ctl.wr_en    = 1'b1;
               wr_data.used = 1'b1;
               res_in       = '{hit: 1'b1, frame: wsc_pkg::FRAME_W'(idx_ff),
                                evicted_valid: 1'b0, evicted_page: '0};
               state_in     = ST_RESP;
            end else if (idx_ff == IW'(FRAMES - 1)) begin
               cnt_in   = '0;
               state_in = ST_SRD;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_HRD;
            end
         end
         ST_SRD: begin
            // Advance the hand and fetch the frame under it.
            ctl.rd_en = 1'b1;
            rd_addr   = hand_nx;
            hand_in   = hand_nx;
            cnt_in    = cnt_ff + CW'(1);
            state_in  = ST_SEV;
         end
         ST_SEV: begin
            wr_addr = hand_ff;
            if (!rd_valid) begin
               // Empty frame: take it, nothing evicted.
               ctl.wr_en    = 1'b1;
               ctl.fill_inc = 1'b1;
               res_in       = '{hit: 1'b0, frame: wsc_pkg::FRAME_W'(hand_ff),
                                evicted_valid: 1'b0, evicted_page: '0};
               state_in     = ST_RESP;
            end else if ((!rd_data.used && age >= theta_ff) || cnt_ff == CW'(FRAMES)) begin
               // Old unused frame, or a full revolution without a victim.
               ctl.wr_en = 1'b1;
               res_in    = '{hit: 1'b0, frame: wsc_pkg::FRAME_W'(hand_ff),
                             evicted_valid: 1'b1, evicted_page: rd_data.page};
               state_in  = ST_RESP;
            end else begin
               // Skip: a used frame loses its bit and gets restamped.
               if (rd_data.used) begin
                  ctl.wr_en = 1'b1;
                  wr_data   = '{page: rd_data.page, used: 1'b0, stamp: now_ff};
               end
               state_in = ST_SRD;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on completion, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offs_ff      <= wsc_pkg::OFFS_RESET;
         theta_ff     <= wsc_pkg::THETA_RESET;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offs_ff      <= offs_in;
         theta_ff     <= theta_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      now_ff  <= now_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_HRD) else $error("accepted request did not start scan");
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hit |-> !rsp_ff.evicted_valid && rsp_ff.evicted_page == '0)
      else $error("hit reports an eviction");
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEV |-> cnt_ff <= CW'(FRAMES) && cnt_ff != '0)
      else $error("sweep step count out of range");
   a_load_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result loaded outside completion");
`endif

endmodule

// ===== bench/wsclock_page_replacement_tb.sv =====
// Self-checking testbench for the WSClock page replacement block.
`timescale 1ns / 100ps

module wsclock_page_replacement_tb;

   localparam int ADDR_W   = wsc_pkg::ADDR_W;
   localparam int TIME_W   = wsc_pkg::TIME_W;
   localparam int PAGE_W   = wsc_pkg::PAGE_W;
   localparam int FRAME_W  = wsc_pkg::FRAME_W;
   localparam int OFFS_W   = wsc_pkg::OFFS_W;
   localparam int CSR_W    = wsc_pkg::CSR_W;
   localparam int CSR_IX_W = wsc_pkg::CSR_IX_W;

   localparam int NFRAMES = 1024;
   localparam int POOL    = 1100;
   localparam logic [PAGE_W-1:0] PMASK = {PAGE_W{1'b1}};

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   wsc_pkg::req_type req_data;
   wsc_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   wsclock_page_replacement #(.FRAMES(NFRAMES)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow page table: contents, valid and use bits, stamps, hand, registers.
   logic [PAGE_W-1:0] shadow_page [NFRAMES];
   bit                shadow_valid [NFRAMES];
   bit                shadow_used [NFRAMES];
   logic [TIME_W-1:0] shadow_stamp [NFRAMES];
   int unsigned       shadow_hand;
   logic [OFFS_W-1:0] cur_offset;
   logic [TIME_W-1:0] cur_theta;

   wsc_pkg::req_type pending_accesses [$];
   wsc_pkg::rsp_type expected_lookups [$];
   logic [PAGE_W-1:0] page_pool [POOL];

   int mismatches, checked, hits_seen, evictions_seen, empties_seen;
   bit taken, burst;
   int gap_left, stall_left;
   logic [TIME_W-1:0] vtime;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #1s;
      $display("wsclock_page_replacement_tb: FAIL");
      $finish;
   end

   // Compute the lookup result and advance the shadow table, one access.
   function automatic wsc_pkg::rsp_type lookup_page(wsc_pkg::req_type r);
      wsc_pkg::rsp_type o;
      logic [PAGE_W-1:0] pg;
      int unsigned v;
      bit found, was_used;
      pg = PAGE_W'((r.address >> cur_offset) & {12'd0, PMASK});
      o = '0;
      for (int i = 0; i < NFRAMES; i++) begin
         if (shadow_valid[i] && shadow_page[i] == pg) begin
            shadow_used[i] = 1'b1;
            shadow_stamp[i] = r.now;
            o.hit = 1'b1;
            o.frame = FRAME_W'(i);
            return o;
         end
      end
      found = 1'b0;
      v = shadow_hand;
      for (int i = 0; i < NFRAMES; i++) begin
         shadow_hand = (shadow_hand + 1) % NFRAMES;
         v = shadow_hand;
         if (!shadow_valid[v]) begin
            found = 1'b1;
            break;
         end
         was_used = shadow_used[v];
         shadow_used[v] = 1'b0;
         if (was_used) begin
            shadow_stamp[v] = r.now;
            continue;
         end
         if (TIME_W'(r.now - shadow_stamp[v]) < cur_theta) continue;
         found = 1'b1;
         break;
      end
      if (!found) v = shadow_hand;
      if (shadow_valid[v]) begin
         o.evicted_valid = 1'b1;
         o.evicted_page = shadow_page[v];
      end
      shadow_page[v] = pg;
      shadow_valid[v] = 1'b1;
      shadow_used[v] = 1'b0;
      shadow_stamp[v] = r.now;
      o.frame = FRAME_W'(v);
      return o;
   endfunction

   // Build an address for a page under the current offset; random low bits.
   function automatic wsc_pkg::req_type access_for(logic [PAGE_W-1:0] pg,
                                                   logic [TIME_W-1:0] t);
      wsc_pkg::req_type r;
      logic [ADDR_W-1:0] lowmask;
      lowmask = (64'd1 << cur_offset) - 64'd1;
      r.address = (64'(pg) << cur_offset) | ({$urandom, $urandom} & lowmask);
      r.now = t;
      return r;
   endfunction

   // Driver: hold the payload until it is taken, then pop the next access.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_lookups.push_back(lookup_page(req_data));
         taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && !(req_valid && !taken)) begin
         if (gap_left > 0 || pending_accesses.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_data <= pending_accesses.pop_front();
            req_valid <= 1'b1;
            gap_left <= burst ? 0 : $urandom_range(0, 10);
         end
      end
      taken <= 1'b0;
   end

   // Monitor: stall for a drawn number of cycles, compare every transaction.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      wsc_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left <= burst ? 0 : $urandom_range(0, 10);
         if (expected_lookups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = expected_lookups.pop_front();
            checked++;
            if (e.hit) hits_seen++;
            if (e.evicted_valid) evictions_seen++;
            if (!e.hit && !e.evicted_valid) empties_seen++;
            if (rsp_data.hit !== e.hit || rsp_data.frame !== e.frame ||
                rsp_data.evicted_valid !== e.evicted_valid ||
                rsp_data.evicted_page !== e.evicted_page) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: expected %p, got %p", checked, e, rsp_data);
            end
         end
      end
   end

   // Wait for the block to go idle, then write a register at a falling edge.
   task automatic drain;
      @(posedge clock);
      while (pending_accesses.size() != 0 || expected_lookups.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IX_W-1:0] ix, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= ix;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (ix == wsc_pkg::CSR_PAGE_OFFSET) cur_offset = OFFS_W'(val);
      else cur_theta = val;
   endtask

   // Queue a random phase: a hot working set, a wider pool to force
   // evictions, some fully random addresses, and occasional time jumps.
   task automatic random_phase(int n);
      int sel;
      wsc_pkg::req_type r;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) vtime = $urandom;
         else vtime = vtime + $urandom_range(0, 400);
         if (sel < 45) r = access_for(page_pool[$urandom_range(0, 31)], vtime);
         else if (sel < 92) r = access_for(page_pool[$urandom_range(0, POOL-1)], vtime);
         else begin
            r.address = {$urandom, $urandom};
            r.now = vtime;
         end
         pending_accesses.push_back(r);
      end
   endtask

   initial begin
      wsc_pkg::req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = wsc_pkg::CSR_PAGE_OFFSET;
      csr_wdata = '0;
      taken = 1'b0;
      burst = 1'b0;
      gap_left = 0;
      stall_left = 0;
      mismatches = 0;
      checked = 0;
      hits_seen = 0;
      evictions_seen = 0;
      empties_seen = 0;
      vtime = 32'hFFFF_F000;
      cur_offset = wsc_pkg::OFFS_RESET;
      cur_theta = wsc_pkg::THETA_RESET;
      shadow_hand = 0;
      for (int i = 0; i < NFRAMES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_used[i] = 1'b0;
         shadow_page[i] = '0;
         shadow_stamp[i] = '0;
      end
      for (int i = 0; i < POOL; i++) page_pool[i] = {$urandom, $urandom} & {12'd0, PMASK};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: address extremes, hit on a repeated page, time at both ends.
      r.address = '0;              r.now = '0;            pending_accesses.push_back(r);
      r.address = '1;              r.now = '1;            pending_accesses.push_back(r);
      r.address = 64'h3FFF;        r.now = 32'd5;         pending_accesses.push_back(r);
      r.address = 64'h4000;        r.now = 32'd6;         pending_accesses.push_back(r);
      r.address = '1;              r.now = 32'd7;         pending_accesses.push_back(r);
      r.address = 64'h5555_5555_5555_5555; r.now = 32'hAAAA_AAAA; pending_accesses.push_back(r);
      r.address = 64'hAAAA_AAAA_AAAA_AAAA; r.now = 32'h5555_5555; pending_accesses.push_back(r);
      r.address = 64'h8000_0000_0000_0000; r.now = 32'h8000_0000; pending_accesses.push_back(r);
      r.address = 64'h0000_0000_0000_1000; r.now = 32'd1;         pending_accesses.push_back(r);
      r.address = 64'h4000;        r.now = 32'd900;       pending_accesses.push_back(r);
      r.address = '0;              r.now = 32'd2000;      pending_accesses.push_back(r);
      drain();

      // Offset 12, theta zero: every unused frame is fair game.
      write_reg(wsc_pkg::CSR_PAGE_OFFSET, CSR_W'(12));
      write_reg(wsc_pkg::CSR_THETA, 32'd0);
      burst = 1'b1;
      random_phase(80);
      drain();
      burst = 1'b0;
      random_phase(320);
      drain();

      // Offset 30, theta maximum: sweeps mostly fail and wrap.
      write_reg(wsc_pkg::CSR_PAGE_OFFSET, CSR_W'(30));
      write_reg(wsc_pkg::CSR_THETA, 32'hFFFF_FFFF);
      random_phase(300);
      drain();

      // Middle settings with a random window.
      write_reg(wsc_pkg::CSR_PAGE_OFFSET, CSR_W'(20));
      write_reg(wsc_pkg::CSR_THETA, CSR_W'($urandom_range(50, 3000)));
      random_phase(450);
      drain();

      write_reg(wsc_pkg::CSR_PAGE_OFFSET, CSR_W'(wsc_pkg::OFFS_RESET));
      write_reg(wsc_pkg::CSR_THETA, wsc_pkg::THETA_RESET);
      burst = 1'b1;
      random_phase(100);
      drain();
      burst = 1'b0;
      random_phase(300);
      drain();

      $display("covered %0d lookups: %0d hits, %0d evictions, %0d empty-frame fills",
               checked, hits_seen, evictions_seen, empties_seen);
      $display("page offsets 12/14/20/30, theta 0/default/random/max, %0d mismatches",
               mismatches);
      if (mismatches == 0 && expected_lookups.size() == 0)
         $display("wsclock_page_replacement_tb: PASS");
      else
         $display("wsclock_page_replacement_tb: FAIL");
      $finish;
   end

endmodule
